// ===== rtl/dmc_pkg.sv =====
// shared constants, types and helper functions of the maze carver
package dmc_pkg;

  localparam int GRID_WIDTH    = 240;
  localparam int GRID_HEIGHT   = 160;
  localparam int STACK_DEPTH   = 8192;
  localparam int WORDS_PER_ROW = 8;
  localparam int BM_DEPTH      = GRID_HEIGHT * WORDS_PER_ROW;
  localparam int BM_AW         = $clog2(BM_DEPTH);
  localparam int SA_W          = $clog2(STACK_DEPTH);
  localparam int SC_W          = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0]  CENTER_X   = 8'(GRID_WIDTH / 2 - 1);
  localparam logic [7:0]  CENTER_Y   = 8'(GRID_HEIGHT / 2 - 1);
  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam logic [31:0] RAND_CLAMP = 32'hfffffffb;
  localparam logic [31:0] RAND_FULL  = 32'hffffffff;
  localparam logic [31:0] PIX_MSB    = 32'h80000000;

  // split points of value / (0xffffffff / count)
  localparam logic [31:0] DIV2   = RAND_FULL / 32'd2;
  localparam logic [31:0] DIV3   = RAND_FULL / 32'd3;
  localparam logic [31:0] DIV3X2 = DIV3 * 32'd2;
  localparam logic [31:0] DIV4   = RAND_FULL / 32'd4;
  localparam logic [31:0] DIV4X2 = DIV4 * 32'd2;
  localparam logic [31:0] DIV4X3 = DIV4 * 32'd3;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_MOVED    = 3'd1,
    ST_BACKTRK  = 3'd2,
    ST_FINISHED = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_READ     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_INIT,
    S_NB,
    S_NB_LAST,
    S_EVAL,
    S_POP_LD,
    S_PICK,
    S_WALL_RD,
    S_WALL_WR,
    S_TGT_RD,
    S_TGT_WR,
    S_RD_MEM,
    S_RD_CAP,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic       clr_init;
    logic       clr_wr;
    logic       start_init;
    logic       nb_rd;
    logic [1:0] nb_idx;
    logic       push;
    logic       lcg_step;
    logic       pop_rd;
    logic       pop_ld;
    logic       set_ovf;
    logic       pick;
    logic       pix_rd;
    logic       pix_wr;
    logic       pix_tgt;
    logic       move;
    logic       rd_mem;
    logic       rd_cap;
    logic       load_out;
    status_e    out_status;
  } dp_cmd_t;

  typedef struct packed {
    req_e req;
    logic ovf;
    logic stk_empty;
    logic stk_full;
    logic any_avail;
    logic clr_last;
    logic rd_ok;
    logic out_free;
  } dp_sts_t;

  function automatic logic [BM_AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
    pix_addr = BM_AW'({y, x[7:5]});
  endfunction

  function automatic logic [31:0] pix_mask(input logic [7:0] x);
    pix_mask = PIX_MSB >> x[4:0];
  endfunction

endpackage

// ===== rtl/dmc_ram.sv =====
// generic single port ram with registered read
module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/dmc_datapath.sv =====
// datapath: bitmap and stack memories, position, generator and result register
module dmc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [15:0]      in_tdata_i,
  input  logic [1:0]       in_tuser_i,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             m_tready_i,
  output logic             m_tvalid_o,
  output logic [55:0]      m_tdata_o,
  output logic [2:0]       m_tuser_o,
  input  dmc_pkg::dp_cmd_t cmd_i,
  output dmc_pkg::dp_sts_t sts_o
);

  logic [1:0]  req_q;
  logic [7:0]  row_q;
  logic [2:0]  word_q;
  logic [31:0] seed_q;
  logic [7:0]  cur_x_q, cur_y_q;
  logic [31:0] lcg_q;
  logic [dmc_pkg::SC_W-1:0] cnt_q, cnt_m1;
  logic        ovf_q, started_q;
  logic [3:0]  avail_q;
  logic        pend_v_q;
  logic [1:0]  pend_idx_q;
  logic [1:0]  dir_q, dir_d;
  logic [dmc_pkg::BM_AW-1:0] clr_q;
  logic [31:0] rd_data_q;
  logic        m_valid_q;
  logic [2:0]  o_status_q;
  logic [7:0]  o_x_q, o_y_q;
  logic [1:0]  o_dir_q;
  logic [31:0] o_data_q;

  logic                      bm_we;
  logic [dmc_pkg::BM_AW-1:0] bm_addr;
  logic [31:0]               bm_wdata, bm_rdata;
  logic                      st_we;
  logic [dmc_pkg::SA_W-1:0]  st_addr;
  logic [15:0]               st_wdata, st_rdata;

  logic [3:0]  inrange;
  logic [7:0]  nb_x, nb_y, px, py;
  logic [7:0]  step_px;
  logic [31:0] rnd;
  logic [2:0]  n_avail;
  logic [1:0]  pick_idx;
  logic [2:0]  seen;
  logic        found;

  assign cnt_m1 = cnt_q - 1'b1;

  assign inrange[0] = cur_y_q > 8'd2;
  assign inrange[1] = (9'(cur_x_q) + 9'd3) < 9'(dmc_pkg::GRID_WIDTH);
  assign inrange[2] = (9'(cur_y_q) + 9'd3) < 9'(dmc_pkg::GRID_HEIGHT);
  assign inrange[3] = cur_x_q > 8'd2;

  // neighbor two pixels away
  always_comb begin
    nb_x = cur_x_q;
    nb_y = cur_y_q;
    case (dmc_pkg::dir_e'(cmd_i.nb_idx))
      dmc_pkg::DIR_N: nb_y = cur_y_q - 8'd2;
      dmc_pkg::DIR_E: nb_x = cur_x_q + 8'd2;
      dmc_pkg::DIR_S: nb_y = cur_y_q + 8'd2;
      dmc_pkg::DIR_W: nb_x = cur_x_q - 8'd2;
      default: ;
    endcase
  end

  // wall or target pixel of the chosen move
  always_comb begin
    step_px = cmd_i.pix_tgt ? 8'd2 : 8'd1;
    px = cur_x_q;
    py = cur_y_q;
    case (dmc_pkg::dir_e'(dir_q))
      dmc_pkg::DIR_N: py = cur_y_q - step_px;
      dmc_pkg::DIR_E: px = cur_x_q + step_px;
      dmc_pkg::DIR_S: py = cur_y_q + step_px;
      dmc_pkg::DIR_W: px = cur_x_q - step_px;
      default: ;
    endcase
  end

  // direction choice from the generator value
  always_comb begin
    rnd      = (lcg_q > dmc_pkg::RAND_CLAMP) ? dmc_pkg::RAND_CLAMP : lcg_q;
    n_avail  = 3'(avail_q[0]) + 3'(avail_q[1]) + 3'(avail_q[2]) + 3'(avail_q[3]);
    pick_idx = 2'd0;
    case (n_avail)
      3'd2: pick_idx = 2'(rnd >= dmc_pkg::DIV2);
      3'd3: pick_idx = 2'(rnd >= dmc_pkg::DIV3) + 2'(rnd >= dmc_pkg::DIV3X2);
      3'd4: pick_idx = 2'(rnd >= dmc_pkg::DIV4) + 2'(rnd >= dmc_pkg::DIV4X2)
                       + 2'(rnd >= dmc_pkg::DIV4X3);
      default: pick_idx = 2'd0;
    endcase
    seen  = 3'd0;
    found = 1'b0;
    dir_d = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (avail_q[k] && !found) begin
        if (seen == 3'(pick_idx)) begin
          dir_d = 2'(k);
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  // bitmap port
  always_comb begin
    bm_we    = 1'b0;
    bm_addr  = '0;
    bm_wdata = '0;
    if (cmd_i.clr_wr) begin
      bm_we   = 1'b1;
      bm_addr = clr_q;
    end else if (cmd_i.start_init) begin
      bm_we    = 1'b1;
      bm_addr  = dmc_pkg::pix_addr(dmc_pkg::CENTER_X, dmc_pkg::CENTER_Y);
      bm_wdata = dmc_pkg::pix_mask(dmc_pkg::CENTER_X);
    end else if (cmd_i.nb_rd) begin
      bm_addr = dmc_pkg::pix_addr(nb_x, nb_y);
    end else if (cmd_i.pix_rd) begin
      bm_addr = dmc_pkg::pix_addr(px, py);
    end else if (cmd_i.pix_wr) begin
      bm_we    = 1'b1;
      bm_addr  = dmc_pkg::pix_addr(px, py);
      bm_wdata = bm_rdata | dmc_pkg::pix_mask(px);
    end else if (cmd_i.rd_mem) begin
      bm_addr = dmc_pkg::BM_AW'({row_q, word_q});
    end
  end

  // stack port
  always_comb begin
    st_we    = 1'b0;
    st_addr  = '0;
    st_wdata = '0;
    if (cmd_i.start_init) begin
      st_we    = 1'b1;
      st_wdata = {dmc_pkg::CENTER_Y, dmc_pkg::CENTER_X};
    end else if (cmd_i.push) begin
      st_we    = 1'b1;
      st_addr  = cnt_q[dmc_pkg::SA_W-1:0];
      st_wdata = {cur_y_q, cur_x_q};
    end else if (cmd_i.pop_rd) begin
      st_addr = cnt_m1[dmc_pkg::SA_W-1:0];
    end
  end

  dmc_ram #(.WIDTH(32), .DEPTH(dmc_pkg::BM_DEPTH)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .addr_i (bm_addr),
    .wdata_i(bm_wdata),
    .rdata_o(bm_rdata)
  );

  dmc_ram #(.WIDTH(16), .DEPTH(dmc_pkg::STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .addr_i (st_addr),
    .wdata_i(st_wdata),
    .rdata_o(st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q      <= 2'd0;
      seed_q     <= 32'd2;
      cur_x_q    <= 8'd0;
      cur_y_q    <= 8'd0;
      lcg_q      <= 32'd0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      started_q  <= 1'b0;
      pend_v_q   <= 1'b0;
      pend_idx_q <= 2'd0;
      clr_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (take_i) begin
        req_q <= in_tuser_i;
      end
      if (cfg_we_i) begin
        seed_q <= cfg_data_i;
      end
      pend_v_q   <= cmd_i.nb_rd;
      pend_idx_q <= cmd_i.nb_idx;
      if (cmd_i.clr_init) begin
        clr_q <= '0;
      end else if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.start_init) begin
        cur_x_q   <= dmc_pkg::CENTER_X;
        cur_y_q   <= dmc_pkg::CENTER_Y;
        lcg_q     <= seed_q;
        ovf_q     <= 1'b0;
        started_q <= 1'b1;
        cnt_q     <= dmc_pkg::SC_W'(1);
      end
      if (cmd_i.push) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.lcg_step) begin
        lcg_q <= lcg_q * dmc_pkg::LCG_MUL + dmc_pkg::LCG_ADD;
      end
      if (cmd_i.pop_rd) begin
        cnt_q <= cnt_m1;
      end
      if (cmd_i.pop_ld) begin
        cur_x_q <= st_rdata[7:0];
        cur_y_q <= st_rdata[15:8];
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.move) begin
        case (dmc_pkg::dir_e'(dir_q))
          dmc_pkg::DIR_N: cur_y_q <= cur_y_q - 8'd2;
          dmc_pkg::DIR_E: cur_x_q <= cur_x_q + 8'd2;
          dmc_pkg::DIR_S: cur_y_q <= cur_y_q + 8'd2;
          dmc_pkg::DIR_W: cur_x_q <= cur_x_q - 8'd2;
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      row_q  <= in_tdata_i[7:0];
      word_q <= in_tdata_i[10:8];
    end
    if (pend_v_q) begin
      avail_q[pend_idx_q] <= inrange[pend_idx_q] && !(|(bm_rdata & dmc_pkg::pix_mask(
                             (pend_idx_q == 2'(dmc_pkg::DIR_E)) ? cur_x_q + 8'd2 :
                             (pend_idx_q == 2'(dmc_pkg::DIR_W)) ? cur_x_q - 8'd2 : cur_x_q)));
    end
    if (cmd_i.pick) begin
      dir_q <= dir_d;
    end
    if (cmd_i.rd_cap) begin
      rd_data_q <= sts_o.rd_ok ? bm_rdata : 32'd0;
    end
    if (cmd_i.load_out) begin
      o_status_q <= cmd_i.out_status;
      o_x_q      <= cur_x_q;
      o_y_q      <= cur_y_q;
      o_dir_q    <= (cmd_i.out_status == dmc_pkg::ST_MOVED) ? dir_q : 2'd0;
      o_data_q   <= (cmd_i.out_status == dmc_pkg::ST_READ) ? rd_data_q : 32'd0;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = o_status_q;
  assign m_tdata_o  = {6'd0, o_data_q, o_dir_q, o_y_q, o_x_q};

  assign sts_o.req       = dmc_pkg::req_e'(req_q);
  assign sts_o.ovf       = ovf_q;
  assign sts_o.stk_empty = (cnt_q == '0);
  assign sts_o.stk_full  = (cnt_q == dmc_pkg::SC_W'(dmc_pkg::STACK_DEPTH));
  assign sts_o.any_avail = |avail_q;
  assign sts_o.clr_last  = (clr_q == dmc_pkg::BM_AW'(dmc_pkg::BM_DEPTH - 1));
  assign sts_o.rd_ok     = started_q && (9'(row_q) < 9'(dmc_pkg::GRID_HEIGHT));
  assign sts_o.out_free  = !m_valid_q || m_tready_i;

endmodule

// ===== rtl/dmc_ctrl.sv =====
// controller: request sequencing state machine
module dmc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             take_o,
  output dmc_pkg::dp_cmd_t cmd_o,
  input  dmc_pkg::dp_sts_t sts_i
);

  dmc_pkg::state_e  state_q, state_d;
  dmc_pkg::status_e res_q, res_d;
  logic [1:0]       nb_q, nb_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::S_IDLE;
      res_q   <= dmc_pkg::ST_STARTED;
      nb_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      nb_q    <= nb_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    nb_d       = nb_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    take_o     = 1'b0;
    case (state_q)
      dmc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          take_o  = 1'b1;
          state_d = dmc_pkg::S_DECODE;
        end
      end
      dmc_pkg::S_DECODE: begin
        case (sts_i.req)
          dmc_pkg::REQ_START: begin
            cmd_o.clr_init = 1'b1;
            state_d        = dmc_pkg::S_CLEAR;
          end
          dmc_pkg::REQ_STEP: begin
            if (sts_i.ovf) begin
              res_d   = dmc_pkg::ST_OVERFLOW;
              state_d = dmc_pkg::S_RESULT;
            end else if (sts_i.stk_empty) begin
              res_d   = dmc_pkg::ST_FINISHED;
              state_d = dmc_pkg::S_RESULT;
            end else begin
              nb_d    = 2'd0;
              state_d = dmc_pkg::S_NB;
            end
          end
          default: begin
            res_d   = dmc_pkg::ST_READ;
            state_d = dmc_pkg::S_RD_MEM;
          end
        endcase
      end
      dmc_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = dmc_pkg::S_INIT;
        end
      end
      dmc_pkg::S_INIT: begin
        cmd_o.start_init = 1'b1;
        res_d            = dmc_pkg::ST_STARTED;
        state_d          = dmc_pkg::S_RESULT;
      end
      dmc_pkg::S_NB: begin
        cmd_o.nb_rd  = 1'b1;
        cmd_o.nb_idx = nb_q;
        nb_d         = nb_q + 2'd1;
        if (nb_q == 2'(dmc_pkg::DIR_W)) begin
          state_d = dmc_pkg::S_NB_LAST;
        end
      end
      dmc_pkg::S_NB_LAST: begin
        state_d = dmc_pkg::S_EVAL;
      end
      dmc_pkg::S_EVAL: begin
        if (!sts_i.any_avail) begin
          cmd_o.pop_rd = 1'b1;
          res_d        = dmc_pkg::ST_BACKTRK;
          state_d      = dmc_pkg::S_POP_LD;
        end else if (sts_i.stk_full) begin
          cmd_o.set_ovf = 1'b1;
          res_d         = dmc_pkg::ST_OVERFLOW;
          state_d       = dmc_pkg::S_RESULT;
        end else begin
          cmd_o.push     = 1'b1;
          cmd_o.lcg_step = 1'b1;
          res_d          = dmc_pkg::ST_MOVED;
          state_d        = dmc_pkg::S_PICK;
        end
      end
      dmc_pkg::S_POP_LD: begin
        cmd_o.pop_ld = 1'b1;
        state_d      = dmc_pkg::S_RESULT;
      end
      dmc_pkg::S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = dmc_pkg::S_WALL_RD;
      end
      dmc_pkg::S_WALL_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = dmc_pkg::S_WALL_WR;
      end
      dmc_pkg::S_WALL_WR: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = dmc_pkg::S_TGT_RD;
      end
      dmc_pkg::S_TGT_RD: begin
        cmd_o.pix_rd  = 1'b1;
        cmd_o.pix_tgt = 1'b1;
        state_d       = dmc_pkg::S_TGT_WR;
      end
      dmc_pkg::S_TGT_WR: begin
        cmd_o.pix_wr  = 1'b1;
        cmd_o.pix_tgt = 1'b1;
        cmd_o.move    = 1'b1;
        state_d       = dmc_pkg::S_RESULT;
      end
      dmc_pkg::S_RD_MEM: begin
        cmd_o.rd_mem = sts_i.rd_ok;
        state_d      = dmc_pkg::S_RD_CAP;
      end
      dmc_pkg::S_RD_CAP: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = dmc_pkg::S_RESULT;
      end
      dmc_pkg::S_RESULT: begin
        cmd_o.out_status = res_q;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = dmc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dmc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dfs_maze_carver_core.sv =====
// top level of the depth-first maze carver
// usage:
//  - slave stream carries one request: tuser holds the request kind (start, step,
//    read), tdata holds the bitmap row and the word within the row for reads
//  - master stream returns exactly one result per request: tuser is the status,
//    tdata the position after the request, the carved direction and read data
//  - cfg channel writes the generator seed; it is always ready, and the user must
//    use it only while no request is in flight (the block does not enforce this)
//  - a step reads the four neighbors over the single bitmap port; a move then
//    does a read-modify-write of the wall and of the target pixel, while a
//    backtrack reloads the position from the stack
//  - a start clears the bitmap one word per cycle (1280 words), then sets up the center
//  - a read fetches and captures the bitmap word; finished answers and steps after
//    an overflow go straight to the result; a step into a full stack stops after
//    the neighbor reads
//  - one request is in flight at a time; tready drops after acceptance and comes
//    back the cycle after the result is loaded
//  - the result sits in an output register, so a stalled receiver holds the
//    result while the next request is already being worked on; only loading
//    the following result waits for the register to drain
//  - reset clears position, generator, stack count and the overflow flag; reads
//    before the first start answer zero, steps answer finished
module dfs_maze_carver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // read_row[7:0], read_word[10:8], zero fill
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // pos_x[7:0], pos_y[15:8], move_dir[17:16],
                                      // bitmap_data[49:18], zero fill
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i      // start_seed
);

  dmc_pkg::dp_cmd_t cmd;
  dmc_pkg::dp_sts_t sts;
  logic             take;

  // seed register takes a write request in any cycle
  assign cfg_ready_o = 1'b1;

  dmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .take_o    (take),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  dmc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_tdata_i(s_axis_tdata),
    .in_tuser_i(s_axis_tuser),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .m_tready_i(m_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

`ifndef ASSERT_OFF
  // never push onto a full stack
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !sts.stk_full) else $error("push onto full stack");

  // every pixel write completes a read issued the cycle before
  a_rmw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pix_wr |-> $past(cmd.pix_rd)) else $error("pixel write without read");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");
`endif

endmodule

// ===== bench/dfs_maze_carver_checker.sv =====
// request/result monitor of the maze carver: mirrors the carving and compares every result
module dfs_maze_carver_checker
  import dmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_o
);

  localparam int          WIDTH_PX  = 240;
  localparam int          HEIGHT_PX = 160;
  localparam int          MAX_DEPTH = 8192;
  localparam logic [31:0] GEN_MUL   = 32'd1103515245;
  localparam logic [31:0] GEN_INC   = 32'd12345;
  localparam logic [31:0] GEN_CLAMP = 32'hfffffffb;
  localparam logic [31:0] GEN_ALL   = 32'hffffffff;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [1:0]  move_dir;
    logic [31:0] bitmap_data;
  } answer_t;

  logic [31:0] maze_bits [0:2047];
  logic [15:0] trail [0:MAX_DEPTH-1];
  int          trail_depth;
  logic [7:0]  here_x, here_y;
  logic [31:0] gen_state, seed;
  logic        ovf_seen;
  answer_t     awaited[$];

  function automatic logic is_open(logic [7:0] x, logic [7:0] y);
    return maze_bits[{y, x[7:5]}][5'd31 - x[4:0]];
  endfunction

  function automatic void open_pixel(logic [7:0] x, logic [7:0] y);
    maze_bits[{y, x[7:5]}][5'd31 - x[4:0]] = 1'b1;
  endfunction

  // work out the answer to one request and carve the mirrored maze
  function automatic answer_t carve_request(logic [1:0] kind, logic [7:0] row, logic [2:0] word);
    answer_t     a;
    dir_e        cand [4];
    int          n;
    logic [31:0] v, pick;
    logic [15:0] e;
    a = '0;
    if (kind == REQ_START) begin
      foreach (maze_bits[i]) maze_bits[i] = '0;
      gen_state = seed;
      ovf_seen = 1'b0;
      here_x = 8'(WIDTH_PX / 2 - 1);
      here_y = 8'(HEIGHT_PX / 2 - 1);
      open_pixel(here_x, here_y);
      trail[0] = {here_y, here_x};
      trail_depth = 1;
      a.status = ST_STARTED;
    end else if (kind == REQ_STEP) begin
      if (ovf_seen) begin
        a.status = ST_OVERFLOW;
      end else if (trail_depth == 0) begin
        a.status = ST_FINISHED;
      end else begin
        n = 0;
        if (here_y > 2 && !is_open(here_x, here_y - 8'd2)) begin
          cand[n] = DIR_N; n++;
        end
        if (int'(here_x) + 3 < WIDTH_PX && !is_open(here_x + 8'd2, here_y)) begin
          cand[n] = DIR_E; n++;
        end
        if (int'(here_y) + 3 < HEIGHT_PX && !is_open(here_x, here_y + 8'd2)) begin
          cand[n] = DIR_S; n++;
        end
        if (here_x > 2 && !is_open(here_x - 8'd2, here_y)) begin
          cand[n] = DIR_W; n++;
        end
        if (n == 0) begin
          trail_depth--;
          e = trail[trail_depth];
          here_x = e[7:0];
          here_y = e[15:8];
          a.status = ST_BACKTRK;
        end else if (trail_depth == MAX_DEPTH) begin
          ovf_seen = 1'b1;
          a.status = ST_OVERFLOW;
        end else begin
          trail[trail_depth] = {here_y, here_x};
          trail_depth++;
          gen_state = gen_state * GEN_MUL + GEN_INC;
          v = (gen_state > GEN_CLAMP) ? GEN_CLAMP : gen_state;
          pick = v / (GEN_ALL / 32'(n));
          if (pick >= 32'(n)) pick = 32'(n - 1);
          a.move_dir = cand[pick];
          case (cand[pick])
            DIR_N: begin
              open_pixel(here_x, here_y - 8'd1);
              open_pixel(here_x, here_y - 8'd2);
              here_y -= 8'd2;
            end
            DIR_E: begin
              open_pixel(here_x + 8'd1, here_y);
              open_pixel(here_x + 8'd2, here_y);
              here_x += 8'd2;
            end
            DIR_S: begin
              open_pixel(here_x, here_y + 8'd1);
              open_pixel(here_x, here_y + 8'd2);
              here_y += 8'd2;
            end
            default: begin
              open_pixel(here_x - 8'd1, here_y);
              open_pixel(here_x - 8'd2, here_y);
              here_x -= 8'd2;
            end
          endcase
          a.status = ST_MOVED;
        end
      end
    end else begin
      // code 3 also decodes as a read
      if (row < HEIGHT_PX) a.bitmap_data = maze_bits[{row, word}];
      a.status = ST_READ;
    end
    a.pos_x = here_x;
    a.pos_y = here_y;
    return a;
  endfunction

  initial begin
    error_count_o = 0;
    pending_o = 0;
    foreach (maze_bits[i]) maze_bits[i] = '0;
    trail_depth = 0;
    here_x = '0;
    here_y = '0;
    gen_state = '0;
    seed = 32'd2;
    ovf_seen = 1'b0;
  end

  always @(posedge clk_i) begin
    answer_t want, got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) seed = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        awaited.push_back(carve_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[10:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = status_e'(m_axis_tuser);
        got.pos_x       = m_axis_tdata[7:0];
        got.pos_y       = m_axis_tdata[15:8];
        got.move_dir    = m_axis_tdata[17:16];
        got.bitmap_data = m_axis_tdata[49:18];
        if (awaited.size() == 0) begin
          $error("result with no request waiting: status %0d", m_axis_tuser);
          error_count_o++;
        end else begin
          want = awaited.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count_o++;
          end
          if (got.pos_x != want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
            error_count_o++;
          end
          if (got.pos_y != want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
            error_count_o++;
          end
          if (got.move_dir != want.move_dir) begin
            $error("move_dir: expected %0d, got %0d", want.move_dir, got.move_dir);
            error_count_o++;
          end
          if (got.bitmap_data != want.bitmap_data) begin
            $error("bitmap_data: expected %h, got %h", want.bitmap_data, got.bitmap_data);
            error_count_o++;
          end
        end
      end
      pending_o = awaited.size();
    end
  end

endmodule

// ===== bench/dfs_maze_carver_core_test.sv =====
// top of the maze carver bench: clock, reset, request stimulus and verdict
module dfs_maze_carver_core_test;
  import dmc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  int error_count, pending;
  int gap_pct, stall_pct;
  bit long_hold;
  int cycles;

  dfs_maze_carver_core DUT (.*);

  dfs_maze_carver_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .error_count_o(error_count),
    .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog on total run length
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one request and wait for its handshake, at times after a random gap
  task automatic send_request(req_e kind, logic [7:0] row, logic [2:0] word);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, word, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // let every result drain, then some quiet cycles for the block to settle
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly steps to grow deep mazes; reads cover every row and word code
  task automatic random_request;
    int pick;
    pick = $urandom_range(999);
    if (pick < 5)
      send_request(REQ_START, 8'($urandom), 3'($urandom));
    else if (pick < 800)
      send_request(REQ_STEP, 8'($urandom), 3'($urandom));
    else if (pick < 950)
      send_request(req_e'($urandom_range(2, 3)),
                   ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(159)),
                   3'($urandom));
    else
      send_request(REQ_READ, 8'($urandom_range(60, 100)), 3'($urandom_range(2, 4)));
  endtask

  initial begin
    logic [31:0] phase_seed [4];
    int          phase_gap [4];
    int          phase_stall [4];
    phase_seed  = '{32'hffffffff, 32'h0, $urandom, $urandom};
    phase_gap   = '{0, 87, 0, 34};
    phase_stall = '{0, 0, 87, 34};
    gap_pct = 0;
    stall_pct = 0;
    long_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle block: reads give zero, steps say finished; then a start, steps, and reads of edge and out-of-range rows
    send_request(REQ_READ, 8'd79, 3'd3);
    send_request(REQ_STEP, 8'd0, 3'd0);
    send_request(req_e'(2'd3), 8'd255, 3'd7);
    send_request(REQ_START, 8'd0, 3'd0);
    send_request(REQ_READ, 8'd79, 3'd3);
    repeat (8) send_request(REQ_STEP, 8'd0, 3'd0);
    send_request(REQ_READ, 8'd159, 3'd7);
    send_request(REQ_READ, 8'd0, 3'd0);
    send_request(REQ_READ, 8'd160, 3'd3);
    send_request(REQ_READ, 8'd255, 3'd7);
    send_request(req_e'(2'd3), 8'd78, 3'd3);
    send_request(REQ_READ, 8'd80, 3'd4);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_seed(phase_seed[ph]);
      gap_pct = phase_gap[ph];
      stall_pct = phase_stall[ph];
      send_request(REQ_START, 8'd0, 3'd0);
      for (int k = 0; k < 450; k++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && k == 100) long_hold = 1'b1;
        // a stretch without any idling in every phase
        if (k == 200) begin
          gap_pct = 0;
          stall_pct = 0;
        end
        if (k == 260) begin
          gap_pct = phase_gap[ph];
          stall_pct = phase_stall[ph];
        end
        random_request();
      end
      drain();
    end

    if (error_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
